FILE: hdl/rksi_pkg.sv
// rksi_pkg: shared types, constants and coefficient tables of the
// runge-kutta stage integrator; used by rksi_ctrl, rksi_dpath and the top level.
package rksi_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned COEF_W    = 33;
  localparam int unsigned COEF_FRAC = 30;
  localparam int unsigned PROD_W    = COEF_W + DW;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [2:0] METHOD_EULER = 3'd0;
  localparam logic [2:0] METHOD_RK2   = 3'd1;
  localparam logic [2:0] METHOD_RK3   = 3'd2;
  localparam logic [2:0] METHOD_RK4   = 3'd3;
  localparam logic [2:0] METHOD_SIX   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_METHOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;

  localparam logic [2:0]  METHOD_RST    = METHOD_RK4;
  localparam logic [30:0] TIME_STEP_RST = 31'd65536;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    logic       mul_scale;
    logic       acc_en;
    logic       sat_en;
    logic       fin_en;
    logic       final_stage;
    logic [2:0] method;
    logic [2:0] stage;
    logic [2:0] idx;
  } rksi_cmd_t;

  function automatic logic [3:0] rksi_stage_total(logic [2:0] m);
    logic [3:0] n;
    case (m)
      METHOD_EULER: n = 4'd1;
      METHOD_RK2:   n = 4'd2;
      METHOD_RK3:   n = 4'd3;
      METHOD_SIX:   n = 4'd6;
      default:      n = 4'd4;
    endcase
    return n;
  endfunction

  // weight for column col; final weights when fin, else row row of the stage table
  function automatic logic signed [COEF_W-1:0] rksi_coef(logic [2:0] m, logic fin,
                                                        logic [2:0] row, logic [2:0] col);
    logic signed [COEF_W-1:0] c;
    logic [5:0]               rc;
    c  = '0;
    rc = {row, col};
    if (fin) begin
      case (m)
        METHOD_EULER: begin
          if (col == 3'd0) c = 33'sd1073741824;
        end
        METHOD_RK2: begin
          if (col == 3'd0 || col == 3'd1) c = 33'sd536870912;
        end
        METHOD_RK3: begin
          case (col)
            3'd0, 3'd2: c = 33'sd178956971;
            3'd1:       c = 33'sd715827883;
            default:    c = '0;
          endcase
        end
        METHOD_SIX: begin
          case (col)
            3'd0:    c = 33'sd105101713;
            3'd2:    c = 33'sd432263214;
            3'd3:    c = 33'sd225955771;
            3'd5:    c = 33'sd310421126;
            default: c = '0;
          endcase
        end
        default: begin
          case (col)
            3'd0, 3'd3: c = 33'sd178956971;
            3'd1, 3'd2: c = 33'sd357913941;
            default:    c = '0;
          endcase
        end
      endcase
    end else begin
      case (m)
        METHOD_RK2: begin
          if (rc == 6'o10) c = 33'sd1073741824;
        end
        METHOD_RK3: begin
          case (rc)
            6'o10:   c = 33'sd536870912;
            6'o20:   c = -33'sd1073741824;
            6'o21:   c = 33'sd2147483648;
            default: c = '0;
          endcase
        end
        METHOD_SIX: begin
          case (rc)
            6'o10:   c = 33'sd214748365;
            6'o20:   c = 33'sd80530637;
            6'o21:   c = 33'sd241591910;
            6'o30:   c = 33'sd322122547;
            6'o31:   c = -33'sd966367642;
            6'o32:   c = 33'sd1288490189;
            6'o40:   c = -33'sd218725186;
            6'o41:   c = 33'sd2684354560;
            6'o42:   c = -33'sd2783775099;
            6'o43:   c = 33'sd1391887550;
            6'o50:   c = 33'sd31670879;
            6'o51:   c = 33'sd367001600;
            6'o52:   c = 33'sd44661570;
            6'o53:   c = 33'sd429867615;
            6'o54:   c = 33'sd66322432;
            default: c = '0;
          endcase
        end
        METHOD_EULER: c = '0;
        default: begin
          case (rc)
            6'o10, 6'o21: c = 33'sd536870912;
            6'o32:        c = 33'sd1073741824;
            default:      c = '0;
          endcase
        end
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hdl/rksi_ctrl.sv
// rksi_ctrl: stage tracking and sequencing state machine of the integrator.
// Depends on rksi_pkg; drives rksi_dpath through rksi_cmd_t.
module rksi_ctrl import rksi_pkg::*; #(
  parameter int unsigned MAX_STAGES = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] method_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rksi_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SAT   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] stage_cnt_q, stage_cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] stage_q, method_q, idx_q;
  logic       final_q;

  logic [2:0] m, s;
  logic [3:0] tot, ns;
  logic       fin, accept, fin_en;

  always_comb begin
    m      = (method_i > METHOD_SIX) ? METHOD_RK4 : method_i;
    tot    = rksi_stage_total(m);
    ns     = (tot > 4'(MAX_STAGES)) ? 4'(MAX_STAGES) : tot;
    s      = ({1'b0, stage_cnt_q} >= ns) ? 3'd0 : stage_cnt_q;
    fin    = (({1'b0, s} + 4'd1) == ns);
    accept = in_valid_i && (state_q == ST_IDLE);
    fin_en = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    stage_cnt_d = stage_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_MAC;
          stage_cnt_d = fin ? 3'd0 : s + 3'd1;
        end
      end
      ST_MAC: begin
        if (idx_q == stage_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_SAT;
      ST_SAT:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_en) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (fin_en) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_cnt_q <= stage_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q  <= s;
      final_q  <= fin;
      method_q <= m;
      idx_q    <= '0;
    end else if (state_q == ST_MAC) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_comb begin
    cmd_o.accept      = accept;
    cmd_o.mul_en      = (state_q == ST_MAC) || (state_q == ST_SCALE);
    cmd_o.mul_scale   = (state_q == ST_SCALE);
    cmd_o.acc_en      = ((state_q == ST_MAC) && (idx_q != 3'd0)) || (state_q == ST_DRAIN);
    cmd_o.sat_en      = (state_q == ST_SAT);
    cmd_o.fin_en      = fin_en;
    cmd_o.final_stage = final_q;
    cmd_o.method      = method_q;
    cmd_o.stage       = (state_q == ST_IDLE) ? s : stage_q;
    cmd_o.idx         = idx_q;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/rksi_dpath.sv
// rksi_dpath: slope store, shared multiplier, accumulator, scaling and
// output register. Depends on rksi_pkg; sequenced by rksi_ctrl.
module rksi_dpath import rksi_pkg::*; #(
  parameter int unsigned MAX_STAGES = 6,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  rksi_cmd_t            cmd_i,
  input  logic [30:0]          time_step_i,
  input  logic signed [DW-1:0] depth_now_i,
  input  logic signed [DW-1:0] slope_i,
  output logic signed [DW-1:0] depth_next_o,
  output logic                 step_done_o,
  output logic [2:0]           stage_index_o
);

  localparam int unsigned IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned SAT_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam longint      SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam longint      SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic signed [SAT_W-1:0] sat_fn(logic signed [63:0] x);
    logic signed [SAT_W-1:0] r;
    if (x > SAT_HI) r = SAT_W'(SAT_HI);
    else if (x < SAT_LO) r = SAT_W'(SAT_LO);
    else r = x[SAT_W-1:0];
    return r;
  endfunction

  logic signed [DW-1:0]     store_q [MAX_STAGES];
  logic signed [DW-1:0]     start_q;
  logic signed [SAT_W-1:0]  sum_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [DW-1:0]     mul_b;
  logic [2:0]               row;
  logic signed [63:0]       res_wide;
  logic signed [DW-1:0]     depth_q;
  logic                     last_q;
  logic [2:0]               user_q;

  always_comb begin
    row      = cmd_i.stage + 3'd1;
    mul_a    = cmd_i.mul_scale ? $signed({2'b00, time_step_i})
                               : rksi_coef(cmd_i.method, cmd_i.final_stage, row, cmd_i.idx);
    mul_b    = cmd_i.mul_scale ? DW'(sum_q) : store_q[cmd_i.idx[IDX_W-1:0]];
    prod_d   = mul_a * mul_b;
    res_wide = 64'(prod_q >>> FRAC_BITS) + 64'(start_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (cmd_i.stage == 3'd0) start_q <= depth_now_i;
      store_q[cmd_i.stage[IDX_W-1:0]] <= slope_i;
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q >>> COEF_FRAC);
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.sat_en) sum_q <= sat_fn(64'(acc_q));
    if (cmd_i.fin_en) begin
      depth_q <= DW'(sat_fn(res_wide));
      last_q  <= cmd_i.final_stage;
      user_q  <= cmd_i.stage;
    end
  end

  assign depth_next_o  = depth_q;
  assign step_done_o   = last_q;
  assign stage_index_o = user_q;

endmodule

FILE: hdl/runge_kutta_stage_integrator.sv
// runge_kutta_stage_integrator: top level with configuration registers and
// stream ports. Depends on rksi_pkg, rksi_ctrl and rksi_dpath.
//
// One input beat carries the depth and its slope for one stage of a time
// step; the block answers one output beat with the depth for the next stage
// or, after the last stage of the method, the new depth with tlast set.
// The configuration channel writes the method (index 0) and the step size
// dt (index 1); it is always ready. The user must see that it is written
// only while no beat is in flight; the block itself does not enforce it.
// An item of stage s runs through the single shared multiplier, one weighted
// slope per cycle for stages 0 to s, then drain, saturate, the dt product
// and the final add. A new input beat is taken only in the idle state, after
// the result of the previous beat has been written to the output register.
// Reset sets RK4 with dt = 1.0 and stage 0; slopes hold no value until
// written. While the receiver stalls the finished beat holds in the output
// register; the block still takes and works on the next input beat and then
// waits with that result until the register is free.
module runge_kutta_stage_integrator import rksi_pkg::*; #(
  parameter int unsigned MAX_STAGES = 6,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // depth_now [31:0], slope [63:32]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // depth_next [31:0]
  output logic                 m_axis_tlast,   // step_done
  output logic [2:0]           m_axis_tuser,   // stage_index [2:0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [30:0]          cfg_data_i
);

  logic [2:0]  method_q;
  logic [30:0] time_step_q;
  rksi_cmd_t   cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= METHOD_RST;
      time_step_q <= TIME_STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_METHOD:    method_q    <= cfg_data_i[2:0];
        CFG_TIME_STEP: time_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rksi_ctrl #(
    .MAX_STAGES (MAX_STAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .method_i    (method_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  rksi_dpath #(
    .MAX_STAGES (MAX_STAGES),
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .time_step_i   (time_step_q),
    .depth_now_i   ($signed(s_axis_tdata[31:0])),
    .slope_i       ($signed(s_axis_tdata[63:32])),
    .depth_next_o  (m_axis_tdata),
    .step_done_o   (m_axis_tlast),
    .stage_index_o (m_axis_tuser)
  );

endmodule
